FILE: design/mnst_pkg.sv
// Package for the MIDI note span tracker: event and span transaction types,
// note table entry type, command and message-kind codes.
// No dependencies.
`default_nettype none

package mnst_pkg;

    // Command codes of an event transaction
    localparam logic [1:0] CMD_CHANNEL   = 2'd0;
    localparam logic [1:0] CMD_END_TRACK = 2'd2;

    // Status byte fields and message kinds
    localparam logic [7:0] KIND_MASK     = 8'hF0;
    localparam logic [7:0] CHAN_MASK     = 8'h0F;
    localparam logic [7:0] KIND_NOTE_OFF = 8'h80;
    localparam logic [7:0] KIND_NOTE_ON  = 8'h90;
    localparam logic [7:0] KIND_PROGRAM  = 8'hC0;

    // Percussion channel starts on its own program
    localparam int         DRUM_CHANNEL  = 10;
    localparam logic [6:0] DRUM_PROGRAM  = 7'd113;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  status;
        logic [6:0]  data_first;
        logic [6:0]  data_second;
        logic [27:0] delta_ticks;
    } evt_item_t;

    typedef struct packed {
        logic [3:0]  span_channel;
        logic [6:0]  span_note;
        logic [31:0] span_start;
        logic [31:0] span_end;
        logic [6:0]  span_program;
    } span_item_t;

    // One note table entry: sounding flag and start time
    typedef struct packed {
        logic        active;
        logic [31:0] start;
    } note_entry_t;

    // Decoded operation carried from the decode stage to the table stage
    typedef enum logic [1:0] {
        OP_NONE     = 2'd0,
        OP_PROGRAM  = 2'd1,
        OP_NOTE_ON  = 2'd2,
        OP_NOTE_OFF = 2'd3
    } note_op_t;

endpackage

`default_nettype wire

FILE: design/midi_note_span_tracker.sv
// MIDI note span tracker top level: decode stage, note table stage, span register.
// Depends on mnst_pkg and mnst_ram.
//
// Usage:
//   evt channel (evt_valid/evt_ready/evt) carries one decoded MIDI event per
//   transaction. The delta is added to the song time before the event is
//   handled; an end-of-track event restarts the time when parallel_tracks is 1.
//   span channel (span_valid/span_ready/span) carries one finished note per
//   transaction: channel, note, start and end time, and the channel program.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes parallel_tracks and is
//   always ready; the user must write it only while no event is in flight,
//   which the block itself does not enforce.
// Flow: one event per cycle unless a span waits (see Stall); the rate is set by
//   the read-modify-write of the note table memory, with forwarding of the last
//   write. A note-off is decoded and its entry read in the accepting cycle, the
//   entry is updated in the table stage, and the span goes to the span register.
// Reset: parallel_tracks is 1, song time 0, channel 10 on program 113, others 0.
//   A clearing pass zeroes all CHANNEL_COUNT*NOTE_COUNT table entries (2048 by
//   default); evt_ready stays low until it ends.
// Stall: while a span waits on span_ready, events that cause no span keep
//   flowing; the next note-off that finds a sounding note holds the pipeline
//   and drops evt_ready until the span register frees.
`default_nettype none

module midi_note_span_tracker
    import mnst_pkg::*;
#(
    parameter int CHANNEL_COUNT = 16,
    parameter int NOTE_COUNT    = 128
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic       evt_valid,
    output logic            evt_ready,
    input  wire evt_item_t  evt,
    output logic            span_valid,
    input  wire logic       span_ready,
    output span_item_t      span,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data
);

    localparam int SLOT_COUNT = CHANNEL_COUNT * NOTE_COUNT;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CH_W       = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int ENTRY_W    = $bits(note_entry_t);

    // Configuration and song time
    logic        parallel_tracks_reg;
    logic [31:0] song_time_reg;
    logic [31:0] song_time_next;

    // Clearing pass
    logic              clearing_reg;
    logic [SLOT_W-1:0] clr_addr_reg;

    // Table stage
    logic              s1_valid_reg;
    note_op_t          s1_op_reg;
    logic [3:0]        s1_chan_reg;
    logic [6:0]        s1_note_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic [31:0]       s1_time_reg;

    // Forwarding of the last table write
    logic              fwd_valid_reg;
    logic [SLOT_W-1:0] fwd_addr_reg;
    note_entry_t       fwd_data_reg;

    // Span output register
    logic       span_valid_reg;
    span_item_t span_reg;

    // Channel programs
    logic [6:0] prog_reg [CHANNEL_COUNT];

    // Decode signals
    logic        evt_accept;
    logic [7:0]  kind;
    logic [7:0]  chan_byte;
    logic [3:0]  chan;
    logic        chan_ok;
    logic        note_ok;
    logic [11:0] slot_full;
    note_op_t    op_dec;

    // Table stage signals
    logic [ENTRY_W-1:0] ram_rd_data;
    note_entry_t        entry;
    logic               s1_emit;
    logic               out_free;
    logic               s1_advance;
    logic               s1_fire;
    logic               ram_wr_en;
    logic [SLOT_W-1:0]  ram_wr_addr;
    note_entry_t        ram_wr_data;

    assign cfg_ready  = 1'b1;
    assign span_valid = span_valid_reg;
    assign span       = span_reg;

    // Hold the pipeline only when a span must be issued and the register is full
    assign out_free   = !span_valid_reg || span_ready;
    assign s1_advance = !s1_valid_reg || !s1_emit || out_free;
    assign s1_fire    = s1_valid_reg && s1_advance;
    assign evt_ready  = !clearing_reg && s1_advance;
    assign evt_accept = evt_valid && evt_ready;

    // Decode the event
    assign kind      = evt.status & KIND_MASK;
    assign chan_byte = evt.status & CHAN_MASK;
    assign chan      = chan_byte[3:0];
    assign chan_ok   = 32'(chan) < CHANNEL_COUNT;
    assign note_ok   = 32'(evt.data_first) < NOTE_COUNT;
    assign slot_full = 12'(chan) * 12'(NOTE_COUNT) + 12'(evt.data_first);

    always_comb
    begin
        op_dec = OP_NONE;
        if (evt.cmd == CMD_CHANNEL && chan_ok)
        begin
            priority if (kind == KIND_PROGRAM)
            begin
                op_dec = OP_PROGRAM;
            end
            else if ((kind == KIND_NOTE_OFF || kind == KIND_NOTE_ON) && note_ok)
            begin
                op_dec = (kind == KIND_NOTE_OFF || evt.data_second == 7'd0)
                         ? OP_NOTE_OFF : OP_NOTE_ON;
            end
            else
            begin
                op_dec = OP_NONE;
            end
        end
    end

    // Advance the song time
    always_comb
    begin
        if (evt.cmd == CMD_END_TRACK)
        begin
            song_time_next = parallel_tracks_reg ? 32'd0 : song_time_reg;
        end
        else
        begin
            song_time_next = song_time_reg + 32'(evt.delta_ticks);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parallel_tracks_reg <= 1'b1;
            song_time_reg       <= 32'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                parallel_tracks_reg <= cfg_data;
            end
            if (evt_accept)
            begin
                song_time_reg <= song_time_next;
            end
        end
    end

    // Load the table stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= evt_accept || (s1_valid_reg && !s1_advance);
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_accept)
        begin
            s1_op_reg   <= op_dec;
            s1_chan_reg <= chan;
            s1_note_reg <= evt.data_first;
            s1_slot_reg <= slot_full[SLOT_W-1:0];
            s1_time_reg <= song_time_next;
        end
    end

    // Note table memory
    mnst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_note_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (evt_accept),
        .rd_addr (slot_full[SLOT_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // Forward the most recent write over the memory read
    assign entry = (fwd_valid_reg && fwd_addr_reg == s1_slot_reg)
                   ? fwd_data_reg : note_entry_t'(ram_rd_data);

    assign s1_emit = s1_valid_reg && s1_op_reg == OP_NOTE_OFF && entry.active;

    // Write back the entry, or zero it during the clearing pass
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = s1_slot_reg;
        ram_wr_data = '0;
        if (clearing_reg)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_reg;
        end
        else if (s1_fire && s1_op_reg == OP_NOTE_ON)
        begin
            ram_wr_en          = 1'b1;
            ram_wr_data.active = 1'b1;
            ram_wr_data.start  = s1_time_reg;
        end
        else if (s1_fire && s1_emit)
        begin
            ram_wr_en          = 1'b1;
            ram_wr_data.active = 1'b0;
            ram_wr_data.start  = entry.start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (ram_wr_en)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_wr_en)
        begin
            fwd_addr_reg <= ram_wr_addr;
            fwd_data_reg <= ram_wr_data;
        end
    end

    // Sweep the note table after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == SLOT_W'(SLOT_COUNT - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Update channel programs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                prog_reg[i] <= (i == DRUM_CHANNEL) ? DRUM_PROGRAM : 7'd0;
            end
        end
        else if (s1_fire && s1_op_reg == OP_PROGRAM)
        begin
            prog_reg[s1_chan_reg[CH_W-1:0]] <= s1_note_reg;
        end
    end

    // Issue the span, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_emit)
        begin
            span_valid_reg <= 1'b1;
        end
        else if (span_ready)
        begin
            span_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_emit)
        begin
            span_reg.span_channel <= s1_chan_reg;
            span_reg.span_note    <= s1_note_reg;
            span_reg.span_start   <= entry.start;
            span_reg.span_end     <= s1_time_reg;
            span_reg.span_program <= prog_reg[s1_chan_reg[CH_W-1:0]];
        end
    end

    // No event enters while the table is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !evt_ready)
        else $error("event accepted during clearing pass");

    // No event is in flight during the clearing pass
    a_idle_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s1_valid_reg)
        else $error("table stage busy during clearing pass");

    // A new span comes only from a note-off in the table stage
    a_span_source: assert property (@(posedge clk) disable iff (!rst_n)
        (span_valid_reg && (!$past(span_valid_reg) || $past(span_ready)))
        |-> ($past(s1_valid_reg) && $past(s1_op_reg) == OP_NOTE_OFF))
        else $error("span issued without a note-off");

    // With the span register free the table stage never holds
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !span_valid_reg |-> s1_advance)
        else $error("table stage held with span register free");

endmodule

`default_nettype wire

FILE: design/mnst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read during write to the same address returns the old contents.
// No dependencies.
`default_nettype none

module mnst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench for midi_note_span_tracker: event stream in, finished note spans out.
// Uses mnst_pkg for the transaction types and codes; predicts every span in SV.

module tb_top;
    import mnst_pkg::*;

    // Command codes that the package leaves unnamed
    localparam logic [1:0]  CMD_TIME_ONLY = 2'd1;
    localparam logic [1:0]  CMD_SPARE     = 2'd3;
    localparam logic [27:0] DELTA_MAX     = 28'hFFF_FFFF;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          PRINT_CAP     = 60;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        evt_valid;
    logic        evt_ready;
    evt_item_t   evt;
    logic        span_valid;
    logic        span_ready = 1'b0;
    span_item_t  span;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;

    // Predicted block state
    logic        restart_on_end;
    logic [31:0] song_clock;
    logic        note_sounding [2048];
    logic [31:0] note_began [2048];
    logic [6:0]  chan_program [16];
    span_item_t  due_spans [$];

    // Bookkeeping
    int          mismatch_count = 0;
    int          events_taken = 0;
    int          spans_checked = 0;
    int          mode_writes = 0;
    int          burst_left = 0;
    bit          tx_gaps = 1'b0;
    int          rx_mode = 0;
    int          hold_off_len = 0;

    midi_note_span_tracker dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt_valid  (evt_valid),
        .evt_ready  (evt_ready),
        .evt        (evt),
        .span_valid (span_valid),
        .span_ready (span_ready),
        .span       (span),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always #2 clk = ~clk;

    // Put the predicted state in its post-reset condition
    task automatic clear_prediction();
        restart_on_end = 1'b1;
        song_clock = '0;
        for (int i = 0; i < 2048; i++)
        begin
            note_sounding[i] = 1'b0;
            note_began[i] = '0;
        end
        for (int c = 0; c < 16; c++)
            chan_program[c] = (c == DRUM_CHANNEL) ? DRUM_PROGRAM : 7'd0;
    endtask

    // Advance song time and the note table by one event; queue any finished span
    task automatic track_event(input evt_item_t e);
        logic [7:0]  kind;
        logic [3:0]  ch;
        logic [10:0] slot;
        span_item_t  s;
        if (e.cmd == CMD_END_TRACK)
        begin
            if (restart_on_end)
                song_clock = '0;
            return;
        end
        song_clock = song_clock + {4'd0, e.delta_ticks};
        if (e.cmd != CMD_CHANNEL)
            return;
        kind = e.status & KIND_MASK;
        ch = e.status[3:0];
        if (kind == KIND_PROGRAM)
        begin
            chan_program[ch] = e.data_first;
            return;
        end
        if (kind != KIND_NOTE_OFF && kind != KIND_NOTE_ON)
            return;
        slot = {ch, e.data_first};
        if (kind == KIND_NOTE_OFF || e.data_second == 7'd0)
        begin
            if (!note_sounding[slot])
                return;
            note_sounding[slot] = 1'b0;
            s.span_channel = ch;
            s.span_note = e.data_first;
            s.span_start = note_began[slot];
            s.span_end = song_clock;
            s.span_program = chan_program[ch];
            due_spans.push_back(s);
        end
        else
        begin
            note_sounding[slot] = 1'b1;
            note_began[slot] = song_clock;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("%0t ns: %s got %0h expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Sample every handshake at the edge: mode writes, events, spans
    always @(posedge clk)
    begin
        span_item_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                restart_on_end = cfg_data;
            if (evt_valid && evt_ready)
            begin
                track_event(evt);
                events_taken++;
            end
            if (span_valid && span_ready)
            begin
                if (due_spans.size() == 0)
                    report_mismatch("span with none expected, note",
                                    32'(span.span_note), '0);
                else
                begin
                    want = due_spans.pop_front();
                    if (span.span_channel !== want.span_channel)
                        report_mismatch("span_channel", 32'(span.span_channel),
                                        32'(want.span_channel));
                    if (span.span_note !== want.span_note)
                        report_mismatch("span_note", 32'(span.span_note),
                                        32'(want.span_note));
                    if (span.span_start !== want.span_start)
                        report_mismatch("span_start", span.span_start, want.span_start);
                    if (span.span_end !== want.span_end)
                        report_mismatch("span_end", span.span_end, want.span_end);
                    if (span.span_program !== want.span_program)
                        report_mismatch("span_program", 32'(span.span_program),
                                        32'(want.span_program));
                    spans_checked++;
                end
            end
        end
    end

    // Span receiver: long hold-off on request, otherwise always ready or a stall pattern
    initial
    begin : receiver
        logic [15:0] ready_mask;
        int          step;
        ready_mask = 16'hFFFF;
        step = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_len != 0)
            begin
                span_ready <= 1'b0;
                repeat (hold_off_len) @(posedge clk);
                hold_off_len = 0;
            end
            else if (rx_mode == 0)
                span_ready <= 1'b1;
            else
            begin
                if (step == 0)
                    ready_mask = ($urandom_range(0, 2) != 0)
                        ? 16'($urandom() | $urandom())
                        : 16'($urandom() & $urandom());
                span_ready <= ready_mask[step];
                step = (step + 1) % 16;
            end
        end
    end

    function automatic evt_item_t pack_event(input logic [1:0] c, input logic [7:0] st,
                                             input logic [6:0] a, input logic [6:0] b,
                                             input logic [27:0] dt);
        evt_item_t e;
        e.cmd = c;
        e.status = st;
        e.data_first = a;
        e.data_second = b;
        e.delta_ticks = dt;
        return e;
    endfunction

    // Mostly note traffic on a few hot slots, with program changes and noise mixed in
    function automatic evt_item_t make_event();
        evt_item_t  e;
        int         pick;
        logic [3:0] ch;
        logic [6:0] note;
        pick = $urandom_range(0, 99);
        ch = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
        note = ($urandom_range(0, 9) < 7) ? 7'($urandom_range(60, 67))
                                          : 7'($urandom_range(0, 127));
        e = pack_event(CMD_CHANNEL, KIND_NOTE_ON | {4'd0, ch}, note,
                       7'($urandom_range(1, 127)), '0);
        case ($urandom_range(0, 9))
            0:       e.delta_ticks = 28'($urandom());
            1, 2:    e.delta_ticks = 28'($urandom_range(0, 1 << 20));
            default: e.delta_ticks = 28'($urandom_range(0, 255));
        endcase
        if (pick < 30)
        begin
            if ($urandom_range(0, 9) == 0)
                e.data_second = 7'd0;
        end
        else if (pick < 60)
        begin
            e.status = KIND_NOTE_OFF | {4'd0, ch};
            e.data_second = 7'($urandom_range(0, 127));
        end
        else if (pick < 68)
        begin
            e.status = KIND_PROGRAM | {4'd0, ch};
            e.data_first = 7'($urandom_range(0, 127));
        end
        else if (pick < 78)
            e.status = 8'($urandom());
        else if (pick < 86)
            e = pack_event(CMD_TIME_ONLY, 8'($urandom()), 7'($urandom()), 7'($urandom()),
                           e.delta_ticks);
        else if (pick < 90)
            e.cmd = CMD_SPARE;
        else if (pick < 94)
            e.cmd = CMD_END_TRACK;
        else
            e = pack_event(2'($urandom()), 8'($urandom()), 7'($urandom()), 7'($urandom()),
                           28'($urandom()));
        return e;
    endfunction

    // Offer one event and hold it until accepted; call right after a rising edge
    task automatic send_event(input evt_item_t e);
        evt_valid <= 1'b1;
        evt <= e;
        do @(posedge clk); while (!evt_ready);
    endtask

    // Send in bursts with random gaps when gaps are enabled
    task automatic offer_event(input evt_item_t e);
        if (tx_gaps && burst_left == 0)
        begin
            evt_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        send_event(e);
    endtask

    // Drop valid, wait for every expected span, then let in-flight events finish
    task automatic settle_spans();
        evt_valid <= 1'b0;
        // Let the monitor record the last accepted event first
        @(posedge clk);
        while (due_spans.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_track_mode(input logic restart);
        cfg_valid <= 1'b1;
        cfg_data <= restart;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        mode_writes++;
    endtask

    task automatic test_directed_cases();
        logic [7:0] drum;
        drum = 8'(DRUM_CHANNEL);
        tx_gaps = 1'b1;
        rx_mode = 1;
        set_track_mode(1'b1);
        // Lowest slot, zero then largest delta
        offer_event(pack_event(CMD_CHANNEL, KIND_NOTE_ON, 7'd0, 7'd127, '0));
        offer_event(pack_event(CMD_CHANNEL, KIND_NOTE_OFF, 7'd0, 7'd0, DELTA_MAX));
        // Highest slot, re-strike, then velocity-zero note-on as release
        offer_event(pack_event(CMD_CHANNEL, KIND_NOTE_ON | 8'd15, 7'd127, 7'd1, 28'd5));
        offer_event(pack_event(CMD_CHANNEL, KIND_NOTE_ON | 8'd15, 7'd127, 7'd64, 28'd7));
        offer_event(pack_event(CMD_CHANNEL, KIND_NOTE_ON | 8'd15, 7'd127, 7'd0, 28'd3));
        // Release of a note that is not sounding
        offer_event(pack_event(CMD_CHANNEL, KIND_NOTE_OFF | 8'd15, 7'd127, 7'd127, 28'd1));
        // Percussion channel on its reset program, then a program change
        offer_event(pack_event(CMD_CHANNEL, KIND_NOTE_ON | drum, 7'd36, 7'd100, 28'd1));
        offer_event(pack_event(CMD_CHANNEL, KIND_NOTE_OFF | drum, 7'd36, 7'd127, 28'd2));
        offer_event(pack_event(CMD_CHANNEL, KIND_PROGRAM | drum, 7'd127, 7'd0, '0));
        offer_event(pack_event(CMD_CHANNEL, KIND_NOTE_ON | drum, 7'd1, 7'd2, 28'd9));
        offer_event(pack_event(CMD_CHANNEL, KIND_NOTE_OFF | drum, 7'd1, 7'd2, 28'd4));
        offer_event(pack_event(CMD_CHANNEL, KIND_PROGRAM | 8'd3, 7'h55, 7'h2A, 28'd0));
        offer_event(pack_event(CMD_CHANNEL, KIND_NOTE_ON | 8'd3, 7'h2A, 7'h55, DELTA_MAX));
        // Other message kinds and commands only move time
        offer_event(pack_event(CMD_CHANNEL, 8'hA3, 7'h2A, 7'h7F, 28'h555_5555));
        offer_event(pack_event(CMD_CHANNEL, 8'hFF, 7'h7F, 7'h7F, 28'd11));
        offer_event(pack_event(CMD_CHANNEL, 8'h00, 7'h2A, 7'h00, 28'd13));
        offer_event(pack_event(CMD_TIME_ONLY, 8'h93, 7'h2A, 7'h00, DELTA_MAX));
        offer_event(pack_event(CMD_SPARE, 8'h83, 7'h2A, 7'h00, 28'hAAA_AAAA));
        offer_event(pack_event(CMD_CHANNEL, KIND_NOTE_OFF | 8'd3, 7'h2A, 7'h40, 28'd6));
        // Track end restarts time; its delta is ignored
        offer_event(pack_event(CMD_CHANNEL, KIND_NOTE_ON | 8'd5, 7'h7F, 7'h7F, 28'd21));
        offer_event(pack_event(CMD_END_TRACK, 8'hFF, 7'h7F, 7'h7F, DELTA_MAX));
        offer_event(pack_event(CMD_CHANNEL, KIND_NOTE_OFF | 8'd5, 7'h7F, 7'h00, '0));
        settle_spans();
    endtask

    task automatic test_chained_tracks(input int count);
        tx_gaps = 1'b1;
        rx_mode = 1;
        set_track_mode(1'b0);
        // Time runs on across a track end
        offer_event(pack_event(CMD_CHANNEL, KIND_NOTE_ON | 8'd7, 7'd64, 7'd90, 28'd100));
        offer_event(pack_event(CMD_END_TRACK, 8'h00, 7'd0, 7'd0, DELTA_MAX));
        offer_event(pack_event(CMD_CHANNEL, KIND_NOTE_OFF | 8'd7, 7'd64, 7'd0, 28'd50));
        for (int i = 0; i < count; i++)
            offer_event(make_event());
        settle_spans();
    endtask

    task automatic test_random_traffic(input int count, input logic restart,
                                       input bit gaps, input int rx);
        tx_gaps = gaps;
        rx_mode = rx;
        set_track_mode(restart);
        for (int i = 0; i < count; i++)
        begin
            // Pause the sender midway until every span is back
            if (i == count / 2)
                settle_spans();
            offer_event(make_event());
        end
        settle_spans();
    endtask

    // Hold the receiver off while note pairs keep coming, so the input stalls
    task automatic test_output_backpressure(input int pairs);
        logic [3:0] ch;
        logic [6:0] note;
        tx_gaps = 1'b0;
        rx_mode = 1;
        set_track_mode(1'b1);
        hold_off_len = 500;
        for (int i = 0; i < pairs; i++)
        begin
            ch = 4'($urandom_range(0, 15));
            note = 7'($urandom_range(0, 127));
            send_event(pack_event(CMD_CHANNEL, KIND_NOTE_ON | {4'd0, ch}, note,
                                  7'($urandom_range(1, 127)), 28'($urandom_range(0, 64))));
            send_event(pack_event(CMD_CHANNEL, KIND_NOTE_OFF | {4'd0, ch}, note,
                                  7'($urandom_range(0, 127)), 28'($urandom_range(0, 64))));
        end
        settle_spans();
    endtask

    initial
    begin
        rst_n = 1'b0;
        evt_valid = 1'b0;
        evt = '0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        clear_prediction();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_chained_tracks(350);
        test_random_traffic(500, 1'b1, 1'b1, 1);
        test_random_traffic(450, 1'b0, 1'b0, 0);
        test_output_backpressure(125);

        repeat (8) @(posedge clk);
        // Every predicted span must have come out
        if (due_spans.size() != 0)
            report_mismatch("spans never delivered", 32'(due_spans.size()), '0);
        $display("Run covered %0d events and %0d spans over %0d track mode writes,",
                 events_taken, spans_checked, mode_writes);
        $display("with bursty and full-rate input, output stalls and a long output hold-off.");
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d spans still expected", due_spans.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
